FILE: design/eds_pkg.sv
// shared types, constants and field layouts for the explicit diffusion stepper
package eds_pkg;

    localparam int DEFAULT_GRID_POINTS = 64;
    localparam int VALUE_W             = 32;
    localparam int INDEX_W             = 6;
    localparam int RATIO_W             = 16;
    localparam int POINTS_W            = 7;
    localparam int ROW_MIN             = 3;
    localparam int APB_ADDR_W          = 3;
    localparam int APB_DATA_W          = 32;
    localparam int LAP_W               = VALUE_W + 3;
    localparam int PROD_W              = LAP_W + RATIO_W + 1;
    localparam int FRAC_W              = 16;

    localparam logic [POINTS_W-1:0] POINTS_RESET = POINTS_W'(64);

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // register indexes, taken from paddr[2]
    localparam logic REG_RATIO  = 1'b0;
    localparam logic REG_POINTS = 1'b1;

    // what the update unit does with one point
    typedef enum logic [1:0] {
        KIND_INTERIOR = 2'd0,
        KIND_LEFT     = 2'd1,
        KIND_RIGHT    = 2'd2,
        KIND_HOLD     = 2'd3
    } point_kind_t;

    // control that travels with a point through the update pipe
    typedef struct packed {
        logic        valid;
        logic        emit;
        logic        last;
        point_kind_t kind;
    } stage_ctrl_t;

    typedef struct packed {
        logic                       command;
        logic [INDEX_W-1:0]         point_index;
        logic signed [VALUE_W-1:0]  point_value;
        logic signed [VALUE_W-1:0]  left_boundary;
        logic signed [VALUE_W-1:0]  right_boundary;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]         out_index;
        logic signed [VALUE_W-1:0]  out_value;
        logic                       row_last;
    } result_t;

endpackage

FILE: design/eds_cell.sv
// one grid cell of the shifting row: holds a point, takes a load or its neighbor's value
module eds_cell (
    input  logic                                clk,
    input  logic                                load_en,
    input  logic signed [eds_pkg::VALUE_W-1:0]  load_value,
    input  logic                                shift_en,
    input  logic signed [eds_pkg::VALUE_W-1:0]  shift_in,
    output logic signed [eds_pkg::VALUE_W-1:0]  value
);
    import eds_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (load_en)
        begin
            value_next = load_value;
        end
        else if (shift_en)
        begin
            value_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: design/eds_update.sv
// three-point update pipe: laplacian, ratio multiply, round, add and saturate, or boundary/held value by kind
module eds_update #(
    parameter int GRID_POINTS = eds_pkg::DEFAULT_GRID_POINTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  eds_pkg::stage_ctrl_t                ctrl_in,
    input  logic [$clog2(GRID_POINTS)-1:0]      idx_in,
    input  logic signed [eds_pkg::VALUE_W-1:0]  center,
    input  logic signed [eds_pkg::VALUE_W-1:0]  left_nb,
    input  logic signed [eds_pkg::VALUE_W-1:0]  right_nb,
    input  logic signed [eds_pkg::VALUE_W-1:0]  left_bnd,
    input  logic signed [eds_pkg::VALUE_W-1:0]  right_bnd,
    input  logic [eds_pkg::RATIO_W-1:0]         ratio,
    output eds_pkg::stage_ctrl_t                ctrl_out,
    output logic [$clog2(GRID_POINTS)-1:0]      idx_out,
    output logic signed [eds_pkg::VALUE_W-1:0]  value_out
);
    import eds_pkg::*;

    localparam int IDX_W = $clog2(GRID_POINTS);
    localparam int SUM_W = PROD_W - FRAC_W + 1;

    // stage a: laplacian
    stage_ctrl_t               ctrl_a_reg;
    logic [IDX_W-1:0]          idx_a_reg;
    logic signed [VALUE_W-1:0] u_a_reg;
    logic signed [LAP_W-1:0]   lap_a_reg;
    logic signed [LAP_W-1:0]   lap_a_next;

    // stage b: product
    stage_ctrl_t               ctrl_b_reg;
    logic [IDX_W-1:0]          idx_b_reg;
    logic signed [VALUE_W-1:0] u_b_reg;
    logic signed [PROD_W-1:0]  prod_b_reg;
    logic signed [PROD_W-1:0]  prod_b_next;

    logic signed [SUM_W-1:0]   sum_c;
    logic signed [VALUE_W-1:0] sat_c;

    assign lap_a_next = LAP_W'(right_nb) - (LAP_W'(center) <<< 1) + LAP_W'(left_nb);
    assign prod_b_next = PROD_W'(lap_a_reg) * PROD_W'($signed({1'b0, ratio}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_a_reg <= ctrl_in;
            ctrl_b_reg <= ctrl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            idx_a_reg       <= idx_in;
            u_a_reg         <= center;
            lap_a_reg       <= lap_a_next;
            idx_b_reg       <= idx_a_reg;
            u_b_reg         <= u_a_reg;
            prod_b_reg      <= prod_b_next;
        end
    end

    // floor((p + 2^15) / 2^16) is the shifted product plus bit 15
    assign sum_c = SUM_W'(u_b_reg) + SUM_W'($signed(prod_b_reg[PROD_W-1:FRAC_W]))
                 + SUM_W'({1'b0, prod_b_reg[FRAC_W-1]});

    always_comb
    begin
        if (sum_c[SUM_W-1:VALUE_W-1] == '0 || sum_c[SUM_W-1:VALUE_W-1] == '1)
        begin
            sat_c = sum_c[VALUE_W-1:0];
        end
        else if (sum_c[SUM_W-1])
        begin
            sat_c = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            sat_c = {1'b0, {(VALUE_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        case (ctrl_b_reg.kind)
            KIND_INTERIOR: value_out = sat_c;
            KIND_LEFT:     value_out = left_bnd;
            KIND_RIGHT:    value_out = right_bnd;
            KIND_HOLD:     value_out = u_b_reg;
            default:       value_out = u_b_reg;
        endcase
    end

    assign ctrl_out = ctrl_b_reg;
    assign idx_out  = idx_b_reg;

endmodule

FILE: design/explicit_diffusion_stepper.sv
// top level of the explicit diffusion stepper: apb registers, control, cell ring, result beat
// The row lives in a ring of GRID_POINTS cells, cell k holding grid point k while the
// block is idle. A load item writes one cell in a single cycle and gives no result beat;
// an index at or beyond GRID_POINTS is dropped. A step item rotates the whole ring once:
// each cycle the ring moves, the head cell feeds the update pipe together with its left neighbor
// (held in a register) and its right neighbor (the next cell), and the new value comes back
// in at the tail after the stage a and stage b registers of the pipe; a step turns the whole
// ring whatever points_in_use is, and emits points_in_use beats, one per cycle while the
// result port takes them, index 0 first, with row_last on the final one. A stalled result
// port stops the ring, the update pipe and the step counter together. New items are taken
// only between steps. No clearing pass runs after reset; grid points must be loaded before
// a step reads them. points_in_use below 3 acts as 3 and above GRID_POINTS acts as
// GRID_POINTS. Registers: diffusion_ratio at byte address 0 (unsigned Q0.16), points_in_use
// at byte address 4.
module explicit_diffusion_stepper #(
    parameter int GRID_POINTS = eds_pkg::DEFAULT_GRID_POINTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // apb configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [eds_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [eds_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [eds_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    // item channel
    input  logic                               item_valid,
    output logic                               item_ready,
    input  eds_pkg::item_t                     item,
    // result channel
    output logic                               result_valid,
    input  logic                               result_ready,
    output eds_pkg::result_t                   result
);
    import eds_pkg::*;

    localparam int IDX_W = $clog2(GRID_POINTS);
    localparam int CNT_W = $clog2(GRID_POINTS + 2);
    localparam int NW    = $clog2(GRID_POINTS + 1);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GRID_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_ROW  = CNT_W'(GRID_POINTS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_STEP = 2'b10
    } state_t;

    // configuration registers
    logic [RATIO_W-1:0]  ratio_reg;
    logic [POINTS_W-1:0] points_reg;
    logic                cfg_write;

    // control
    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                item_accept;
    logic                load_accept;
    logic                step_accept;
    logic                advance;
    logic                ring_shift;

    // step boundaries, captured when the step beat is taken
    logic signed [VALUE_W-1:0] left_bnd_reg;
    logic signed [VALUE_W-1:0] right_bnd_reg;
    logic signed [VALUE_W-1:0] prev_reg;

    // effective row size and the point being issued
    logic [NW-1:0]       row_size;
    logic [CNT_W-1:0]    row_end;
    stage_ctrl_t         issue_ctrl;

    // cell ring
    logic signed [VALUE_W-1:0] cell_val [GRID_POINTS];

    // update pipe output
    stage_ctrl_t               upd_ctrl;
    logic [IDX_W-1:0]          upd_idx;
    logic signed [VALUE_W-1:0] upd_value;

    // result beat register
    logic    result_valid_reg;
    logic    result_valid_next;
    result_t result_reg;

    // ---------------- apb port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg  <= '0;
            points_reg <= POINTS_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_RATIO:  ratio_reg  <= pwdata[RATIO_W-1:0];
                REG_POINTS: points_reg <= pwdata[POINTS_W-1:0];
                default:    ratio_reg  <= ratio_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_RATIO:  prdata = APB_DATA_W'(ratio_reg);
            REG_POINTS: prdata = APB_DATA_W'(points_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------- control ----------------
    // the ring, update pipe and counter all move only when the result register can take a beat
    assign advance     = !result_valid_reg || result_ready;
    assign item_ready  = (state_reg == ST_IDLE);
    assign item_accept = item_valid && item_ready;
    assign load_accept = item_accept && (item.command == CMD_LOAD);
    assign step_accept = item_accept && (item.command == CMD_STEP);
    assign ring_shift  = (state_reg == ST_STEP) && advance;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (step_accept)
                begin
                    state_next = ST_STEP;
                    cnt_next   = '0;
                end
            end
            ST_STEP:
            begin
                if (advance)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_accept)
        begin
            left_bnd_reg  <= item.left_boundary;
            right_bnd_reg <= item.right_boundary;
        end
        // left neighbor of the point at the head
        if (ring_shift)
        begin
            prev_reg <= cell_val[0];
        end
    end

    // clamp the row size to [3, GRID_POINTS]
    always_comb
    begin
        if (points_reg < POINTS_W'(ROW_MIN))
        begin
            row_size = NW'(ROW_MIN);
        end
        else if (int'(points_reg) > GRID_POINTS)
        begin
            row_size = NW'(GRID_POINTS);
        end
        else
        begin
            row_size = NW'(points_reg);
        end
    end

    assign row_end = CNT_W'(row_size) - CNT_W'(1);

    // classify the point at the head of the ring
    always_comb
    begin
        issue_ctrl.valid = (state_reg == ST_STEP) && (cnt_reg < CNT_ROW);
        issue_ctrl.emit  = (cnt_reg < CNT_W'(row_size));
        issue_ctrl.last  = (cnt_reg == row_end);
        if (cnt_reg == '0)
        begin
            issue_ctrl.kind = KIND_LEFT;
        end
        else if (cnt_reg == row_end)
        begin
            issue_ctrl.kind = KIND_RIGHT;
        end
        else if (cnt_reg < row_end)
        begin
            issue_ctrl.kind = KIND_INTERIOR;
        end
        else
        begin
            issue_ctrl.kind = KIND_HOLD;
        end
    end

    // ---------------- cell ring ----------------
    // values move toward cell 0; updated values re-enter at the last cell
    for (genvar k = 0; k < GRID_POINTS; k++)
    begin : g_cell
        logic                      load_en;
        logic signed [VALUE_W-1:0] shift_in;

        assign load_en = load_accept && (32'(item.point_index) == k);

        if (k == GRID_POINTS - 1)
        begin : g_tail
            assign shift_in = upd_value;
        end
        else
        begin : g_body
            assign shift_in = cell_val[k + 1];
        end

        eds_cell u_cell (
            .clk        (clk),
            .load_en    (load_en),
            .load_value (item.point_value),
            .shift_en   (ring_shift),
            .shift_in   (shift_in),
            .value      (cell_val[k])
        );
    end

    // ---------------- update pipe ----------------
    eds_update #(
        .GRID_POINTS (GRID_POINTS)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ctrl_in   (issue_ctrl),
        .idx_in    (cnt_reg[IDX_W-1:0]),
        .center    (cell_val[0]),
        .left_nb   (prev_reg),
        .right_nb  (cell_val[1]),
        .left_bnd  (left_bnd_reg),
        .right_bnd (right_bnd_reg),
        .ratio     (ratio_reg),
        .ctrl_out  (upd_ctrl),
        .idx_out   (upd_idx),
        .value_out (upd_value)
    );

    // ---------------- result beat ----------------
    assign result_valid_next = advance ? (upd_ctrl.valid && upd_ctrl.emit) : result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.out_index <= INDEX_W'(upd_idx);
            result_reg.out_value <= upd_value;
            result_reg.row_last  <= upd_ctrl.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: tb/explicit_diffusion_stepper_tb.sv
// self-checking testbench for the explicit diffusion stepper: scoreboard class and drivers
`timescale 1ns / 100ps

module explicit_diffusion_stepper_tb;
    import eds_pkg::*;

    localparam int GRID           = DEFAULT_GRID_POINTS;
    // a step keeps the ring turning even after its last beat
    localparam int SETTLE_CYCLES  = GRID + 8;
    // cycles without any handshake or bus access before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic signed [VALUE_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] Q_MIN = 32'sh8000_0000;

    // scoreboard: own copy of the row and the registers, and the points still owed
    class row_scoreboard;
        logic signed [VALUE_W-1:0] grid [GRID];
        logic [RATIO_W-1:0]        ratio;
        logic [POINTS_W-1:0]       points;
        result_t                   expected_points [$];
        int                        mismatches;
        int                        beats_checked;
        int                        loads_seen;
        int                        steps_seen;

        function int row_length();
            if (points < ROW_MIN)
                return ROW_MIN;
            if (points > GRID)
                return GRID;
            return int'(points);
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        // one ftcs step over the old row, boundaries replaced, row queued for checking
        function void advance_row(logic signed [VALUE_W-1:0] left_end,
                                  logic signed [VALUE_W-1:0] right_end);
            logic signed [VALUE_W-1:0] next_row [GRID];
            longint                    lap;
            longint                    delta;
            longint                    sum;
            int                        n;
            n = row_length();
            for (int i = 1; i + 1 < n; i++) begin
                lap   = longint'(grid[i+1]) - 2 * longint'(grid[i]) + longint'(grid[i-1]);
                delta = (lap * longint'(ratio) + 64'sd32768) >>> FRAC_W;
                sum   = longint'(grid[i]) + delta;
                if (sum > longint'(Q_MAX))
                    next_row[i] = Q_MAX;
                else if (sum < longint'(Q_MIN))
                    next_row[i] = Q_MIN;
                else
                    next_row[i] = VALUE_W'(sum);
            end
            next_row[0]   = left_end;
            next_row[n-1] = right_end;
            for (int i = 0; i < n; i++) begin
                result_t r;
                grid[i]     = next_row[i];
                r.out_index = INDEX_W'(i);
                r.out_value = next_row[i];
                r.row_last  = (i == n - 1);
                expected_points.push_back(r);
            end
        endfunction

        function void note_item(item_t it);
            if (it.command == CMD_LOAD) begin
                // six index bits never reach past the grid
                grid[it.point_index] = it.point_value;
                loads_seen++;
            end else begin
                advance_row(it.left_boundary, it.right_boundary);
                steps_seen++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_points.size() == 0) begin
                $display("%0t: beat with nothing expected: index %0d value %0d last %0b",
                         $time, got.out_index, $signed(got.out_value), got.row_last);
                mismatches++;
                return;
            end
            want = expected_points.pop_front();
            beats_checked++;
            if (got.out_index !== want.out_index) begin
                $display("%0t: out_index expected %0d, got %0d",
                         $time, want.out_index, got.out_index);
                mismatches++;
            end
            if (got.out_value !== want.out_value) begin
                $display("%0t: out_value at %0d expected %0d, got %0d", $time,
                         want.out_index, $signed(want.out_value), $signed(got.out_value));
                mismatches++;
            end
            if (got.row_last !== want.row_last) begin
                $display("%0t: row_last at %0d expected %0b, got %0b",
                         $time, want.out_index, want.row_last, got.row_last);
                mismatches++;
            end
        endfunction
    endclass

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    // block inputs, all known from time zero
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic                  item_valid   = 1'b0;
    item_t                 item         = '0;
    logic                  result_ready = 1'b0;

    // block outputs
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  item_ready;
    logic                  result_valid;
    result_t               result;

    explicit_diffusion_stepper dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    row_scoreboard sb;

    // idle rates in percent, changed per phase
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    // grid points written so far; a step may only read loaded points
    logic [GRID-1:0] loaded = '0;

    int quiet_cycles = 0;

    // result side: check every accepted beat, then pick next cycle's ready
    always @(posedge clk) begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no beat on either channel and no bus access
    always @(posedge clk) begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // apb write: setup cycle, access cycle, then an idle gap so writes never overlap
    task automatic apb_write(input logic reg_sel, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // drop valid, drain every owed beat, then let the ring finish its turn
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // registers are only touched with the block idle
    task automatic configure(input logic [RATIO_W-1:0] ratio, input logic [POINTS_W-1:0] points);
        wait_idle();
        apb_write(REG_RATIO, APB_DATA_W'(ratio));
        apb_write(REG_POINTS, APB_DATA_W'(points));
        sb.ratio  = ratio;
        sb.points = points;
    endtask

    // present one item and hold it until the beat; valid stays high for a follow-on item
    task automatic send_item(input item_t it);
        int n;
        while ($urandom_range(99) < send_gap_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_item(it);
        n = sb.row_length();
        if (it.command == CMD_LOAD)
            loaded[it.point_index] = 1'b1;
        else
            for (int i = 0; i < n; i++)
                loaded[i] = 1'b1;
    endtask

    // mix of full-range, small, mid-range and extreme q16.16 values
    function automatic logic signed [VALUE_W-1:0] random_value();
        case ($urandom_range(3))
            0:       return VALUE_W'($urandom);
            1:       return VALUE_W'(int'($urandom_range(1 << 20)) - (1 << 19));
            2:       return VALUE_W'(int'($urandom_range(1 << 26)) - (1 << 25));
            default: begin
                case ($urandom_range(3))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    // unused fields carry random junk, which the block must ignore
    task automatic load_point(input int idx, input logic signed [VALUE_W-1:0] value);
        item_t it;
        it.command        = CMD_LOAD;
        it.point_index    = INDEX_W'(idx);
        it.point_value    = value;
        it.left_boundary  = random_value();
        it.right_boundary = random_value();
        send_item(it);
    endtask

    task automatic step_row(input logic signed [VALUE_W-1:0] left_end,
                            input logic signed [VALUE_W-1:0] right_end);
        item_t it;
        it.command        = CMD_STEP;
        it.point_index    = INDEX_W'($urandom_range(GRID - 1));
        it.point_value    = random_value();
        it.left_boundary  = left_end;
        it.right_boundary = right_end;
        send_item(it);
    endtask

    // random item: a step in 45 percent of draws once the row is loaded; a step that would read an
    // unloaded point turns into a load of the lowest missing one
    function automatic item_t random_item();
        item_t it;
        int    n;
        n                 = sb.row_length();
        it.point_index    = INDEX_W'($urandom_range(GRID - 1));
        it.point_value    = random_value();
        it.left_boundary  = random_value();
        it.right_boundary = random_value();
        it.command        = CMD_LOAD;
        if ($urandom_range(99) < 45) begin
            it.command = CMD_STEP;
            for (int i = n - 1; i >= 0; i--)
                if (!loaded[i]) begin
                    it.command     = CMD_LOAD;
                    it.point_index = INDEX_W'(i);
                end
        end
        return it;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_item(random_item());
    endtask

    initial begin : stimulus
        sb = new;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // sender idles lightly, receiver stalls often
        send_gap_pct   = 19;
        recv_stall_pct = 54;

        // full-scale ratio on a four-point row of alternating extremes: interior saturates
        configure(16'hffff, 7'd4);
        load_point(0, Q_MAX);
        load_point(1, Q_MIN);
        load_point(2, Q_MAX);
        load_point(3, Q_MIN);
        step_row(Q_MIN, Q_MAX);
        step_row('0, '0);
        // loads outside the row in use are stored but not emitted
        load_point(GRID - 1, 32'sh1234_5678);
        load_point(5, 32'sh0001_0000);
        step_row(Q_MAX, Q_MIN);

        // half ratio on the smallest row: exact halves round toward plus infinity
        configure(16'h8000, 7'd3);
        load_point(0, '0);
        load_point(1, '0);
        load_point(2, 32'sd1);
        step_row('0, -32'sd1);
        load_point(1, '0);
        step_row(32'sd1, '0);

        // random phases over register extremes and every idle mode
        configure(16'hffff, 7'd64);
        run_random(30);
        configure(16'h0000, 7'd2);
        run_random(30);

        send_gap_pct   = 54;
        recv_stall_pct = 19;
        configure(RATIO_W'($urandom), 7'd127);
        run_random(30);
        configure(16'h8000, 7'd0);
        run_random(30);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        configure(RATIO_W'($urandom), POINTS_W'($urandom_range(ROW_MIN, GRID)));
        run_random(30);
        configure(RATIO_W'($urandom), POINTS_W'($urandom_range(127)));
        run_random(30);

        wait_idle();
        $display("covered %0d loads and %0d steps, %0d result beats checked",
                 sb.loads_seen, sb.steps_seen, sb.beats_checked);
        $display("ratios zero, half, full scale and random; row sizes 0, 2, 3, 4, 64, 127");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
design/eds_pkg.sv
design/eds_cell.sv
design/eds_update.sv
design/explicit_diffusion_stepper.sv
tb/explicit_diffusion_stepper_tb.sv
